[hdl/assert_macros.svh]
// Assertion macros shared by the moving-average RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define CMA_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[hdl/cma_pkg.sv]
// Shared constants and register codes for the calibrated moving average.
package cma_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 14;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 18;
    localparam int FRAC_W     = 12;

    // Stream bus widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Largest output value.
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Default window length.
    localparam int WINDOW_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_OFFSET    = 2'd0,
        REG_SENSOR_GAIN      = 2'd1,
        REG_CALIBRATE_ENABLE = 2'd2
    } t_cfg_reg;

    // Register reset values: 0.91 V offset, 2.77/1.62 A/V gain.
    localparam logic [SAMPLE_W-1:0] OFFSET_RST = 14'd3727;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd7004;
    localparam logic                CAL_EN_RST = 1'b1;

endpackage

[hdl/cma_ring.sv]
// Sample ring: window memory, per-entry valid bits and the write index.
module cma_ring #(
    parameter int WINDOW = cma_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [cma_pkg::SAMPLE_W-1:0] i_sample,
    output logic [cma_pkg::SAMPLE_W-1:0] o_old_sample
);

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(WINDOW);

    logic [cma_pkg::SAMPLE_W-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0]            r_vld;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             n_idx;
    logic [cma_pkg::SAMPLE_W-1:0] r_old;

    // Next write position wraps at the window length.
    always_comb begin
        if (r_idx == IDX_W'(WINDOW - 1)) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // Index and valid bits; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_idx        <= n_idx;
            r_vld[r_idx] <= 1'b1;
        end
    end

    // Read the oldest sample and overwrite it with the new one.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_old        <= r_vld[r_idx] ? r_mem[r_idx] : '0;
            r_mem[r_idx] <= i_sample;
        end
    end

    assign o_old_sample = r_old;

    `CMA_ASSERT(a_idx_range, r_idx <= IDX_W'(WINDOW - 1), "ring index out of range")
    `CMA_ASSERT(a_idx_step, i_wr_en |=> r_idx == $past(n_idx), "ring index did not advance")
    `CMA_ASSERT(a_idx_hold, !i_wr_en |=> $stable(r_idx), "ring index moved without a write")

endmodule

[hdl/current_moving_average_calibrated.sv]
// Top level of the calibrated boxcar moving average over sensor samples.
//
//  Channel   Dir  Signals                       Contents
//  s_axis    in   tvalid/tready/tdata[15:0]     sample [13:0]
//  m_axis    out  tvalid/tready/tdata/tuser     filtered_value [17:0]; tuser: saturated
//  cfg       in   i_cfg_wr_en/index/wr_data     offset, gain, calibrate enable
//
// One item is accepted per cycle while the output is not stalled. The ring is read
// and written in the accept cycle; registered stages then update the running sum, the
// offset magnitude, the gain product and the rounding stage, in that order.
// Each stage has its own valid bit, so bubbles fill up while the output is stalled.
// Reset is synchronous; valid bits clear the ring to zeros with no clearing pass.
module current_moving_average_calibrated #(
    parameter int WINDOW = cma_pkg::WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream: tdata = sample [13:0], zero padding [15:14].
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cma_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Output stream: tdata = filtered_value [17:0], zero padding [23:18].
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cma_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Output tuser = saturated [0].
    output logic                            m_axis_tuser,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [cma_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cma_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data
);

    `include "assert_macros.svh"

    localparam int SAMPLE_W = cma_pkg::SAMPLE_W;
    localparam int GAIN_W   = cma_pkg::GAIN_W;
    localparam int OUT_W    = cma_pkg::OUT_W;
    localparam int FRAC_W   = cma_pkg::FRAC_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int SHIFT    = $clog2(WINDOW + 1) - 1;
    localparam int AVG_W    = SUM_W - SHIFT;
    localparam int PROD_W   = AVG_W + GAIN_W;
    localparam int RND_W    = PROD_W + 1 - FRAC_W;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_W) - 1));

    // Configuration registers.
    logic [SAMPLE_W-1:0] r_offset;
    logic [GAIN_W-1:0]   r_gain;
    logic                r_cal_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= cma_pkg::OFFSET_RST;
            r_gain   <= cma_pkg::GAIN_RST;
            r_cal_en <= cma_pkg::CAL_EN_RST;
        end else if (i_cfg_wr_en) begin
            unique case (cma_pkg::t_cfg_reg'(i_cfg_index))
                cma_pkg::REG_SENSOR_OFFSET:    r_offset <= i_cfg_wr_data[SAMPLE_W-1:0];
                cma_pkg::REG_SENSOR_GAIN:      r_gain   <= i_cfg_wr_data[GAIN_W-1:0];
                cma_pkg::REG_CALIBRATE_ENABLE: r_cal_en <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage readiness.
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic mv1, mv2, mv3, mv4, mv5;

    assign rdy5 = !r5_valid || m_axis_tready;
    assign rdy4 = !r4_valid || rdy5;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;

    assign mv1 = s_axis_tvalid && rdy1;
    assign mv2 = r1_valid && rdy2;
    assign mv3 = r2_valid && rdy3;
    assign mv4 = r3_valid && rdy4;
    assign mv5 = r4_valid && rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= s_axis_tvalid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (rdy4) r4_valid <= r3_valid;
            if (rdy5) r5_valid <= r4_valid;
        end
    end

    // Stage 1: ring access and the new sample.
    logic [SAMPLE_W-1:0] r1_sample;
    logic [SAMPLE_W-1:0] old_sample;

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r1_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    cma_ring #(
        .WINDOW(WINDOW)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (mv1),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .o_old_sample(old_sample)
    );

    // Stage 2: running sum drops the oldest sample and adds the new one.
    logic [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (mv2) begin
            r_sum <= r_sum - SUM_W'(old_sample) + SUM_W'(r1_sample);
        end
    end

    // Stage 3: average and its distance from the offset.
    logic [AVG_W-1:0] avg;
    logic [AVG_W-1:0] offset_ext;
    logic [AVG_W-1:0] r3_avg;
    logic [AVG_W-1:0] r3_mag;
    logic             r3_cal;

    assign avg        = r_sum[SUM_W-1:SHIFT];
    assign offset_ext = AVG_W'(r_offset);

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r3_avg <= avg;
            r3_mag <= (avg >= offset_ext) ? (avg - offset_ext) : (offset_ext - avg);
            r3_cal <= r_cal_en;
        end
    end

    // Stage 4: gain product.
    logic [PROD_W-1:0] r4_prod;
    logic [AVG_W-1:0]  r4_avg;
    logic              r4_cal;

    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r4_prod <= PROD_W'(r3_mag) * PROD_W'(r_gain);
            r4_avg  <= r3_avg;
            r4_cal  <= r3_cal;
        end
    end

    // Stage 5: round half up to an integer (Q18.0), saturate, or pass the plain average.
    logic [PROD_W:0]    rnd_full;
    logic [RND_W-1:0]   rnd;
    logic [OUT_W-1:0]   r5_value;
    logic               r5_sat;

    assign rnd_full = {1'b0, r4_prod} + (PROD_W + 1)'(1 << (FRAC_W - 1));
    assign rnd      = rnd_full[PROD_W:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (mv5) begin
            if (!r4_cal) begin
                r5_value <= OUT_W'(r4_avg);
                r5_sat   <= 1'b0;
            end else if (rnd > RND_W'(cma_pkg::OUT_MAX)) begin
                r5_value <= cma_pkg::OUT_MAX;
                r5_sat   <= 1'b1;
            end else begin
                r5_value <= rnd[OUT_W-1:0];
                r5_sat   <= 1'b0;
            end
        end
    end

    // Output ports.
    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r5_valid;
    assign m_axis_tdata  = cma_pkg::OUT_TDATA_W'(r5_value);
    assign m_axis_tuser  = r5_sat;

    `CMA_ASSERT(a_sat_max, r5_valid && r5_sat |-> r5_value == cma_pkg::OUT_MAX, "saturated below max")
    `CMA_ASSERT(a_sum_max, r_sum <= SUM_MAX, "running sum out of range")
    `CMA_ASSERT(a_accept_held, mv1 |=> r1_valid, "accepted item lost in stage one")
    `CMA_ASSERT_NR(a_rst_idle, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule
